[src/kre_pkg.sv]
package kre_pkg;

    localparam int VALUE_W = 32;
    localparam int NDIG    = 10;
    localparam int BCD_W   = 4 * NDIG;
    localparam int BITCNT_W = 6;

    localparam logic [1:0] CFG_SHIFT = 2'd0;
    localparam logic [1:0] CFG_ENTER = 2'd1;
    localparam logic [1:0] CFG_TAB   = 2'd2;

    localparam logic [2:0] ACT_CHAR    = 3'd0;
    localparam logic [2:0] ACT_NUM_NAT = 3'd1;
    localparam logic [2:0] ACT_NUM_FIX = 3'd2;
    localparam logic [2:0] ACT_ENTER   = 3'd3;
    localparam logic [2:0] ACT_TAB     = 3'd4;

    localparam logic [7:0] KEY_ZERO_DIGIT = 8'd39;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_ALIGN,
        ST_PRESS,
        ST_RELEASE
    } state_t;

    typedef struct packed {
        logic load;
        logic shift;
    } dctrl_t;

    typedef struct packed {
        logic       busy;
        logic [3:0] top;
    } dstat_t;

    typedef struct packed {
        logic       upper;
        logic [7:0] key;
    } char_map_t;

    function automatic char_map_t char_map(input logic [7:0] c);
        char_map_t m;
        m.upper = 1'b0;
        m.key   = 8'd0;
        if (c >= 8'd65 && c <= 8'd90)
        begin
            m.upper = 1'b1;
            m.key   = c - 8'd61;
        end
        else if (c >= 8'd97 && c <= 8'd122)
        begin
            m.key = c - 8'd93;
        end
        else if (c == 8'd48)
        begin
            m.key = KEY_ZERO_DIGIT;
        end
        else if (c >= 8'd49 && c <= 8'd57)
        begin
            m.key = c - 8'd19;
        end
        return m;
    endfunction

    function automatic logic [7:0] digit_key(input logic [3:0] d);
        logic [7:0] k;
        if (d == 4'd0)
            k = KEY_ZERO_DIGIT;
        else
            k = 8'd29 + {4'd0, d};
        return k;
    endfunction

endpackage

[src/kre_digit_unit.sv]
module kre_digit_unit
    import kre_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  dctrl_t             ctrl,
    input  logic [VALUE_W-1:0] value,
    output dstat_t             stat
);

    logic [VALUE_W-1:0]  bin_reg, bin_next;
    logic [BCD_W-1:0]    bcd_reg, bcd_next;
    logic [BITCNT_W-1:0] bitcnt_reg, bitcnt_next;
    logic [BCD_W-1:0]    bcd_adj;

    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        bin_next    = bin_reg;
        bcd_next    = bcd_reg;
        bitcnt_next = bitcnt_reg;
        if (ctrl.load)
        begin
            bin_next    = value;
            bcd_next    = '0;
            bitcnt_next = BITCNT_W'(VALUE_W);
        end
        else if (bitcnt_reg != '0)
        begin
            bin_next    = {bin_reg[VALUE_W-2:0], 1'b0};
            bcd_next    = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
            bitcnt_next = bitcnt_reg - BITCNT_W'(1);
        end
        else if (ctrl.shift)
        begin
            bcd_next = {bcd_reg[BCD_W-5:0], 4'd0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bitcnt_reg <= '0;
        else
            bitcnt_reg <= bitcnt_next;
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign stat.busy = (bitcnt_reg != '0);
    assign stat.top  = bcd_reg[BCD_W-1 -: 4];

endmodule

[src/keystroke_report_encoder_unit.sv]
// Keystroke report encoder.
// Input channel (in_valid / in_stall): one typing request per beat: a
// character, a decimal number of natural or fixed length, enter or tab.
// Output channel (out_valid / out_stall): one keyboard report per beat,
// press then release for each keystroke; last marks the request's final one.
// Configuration: cfg_we writes cfg_wdata into the register at cfg_index
// (0 shift modifier, 1 enter key, 2 tab key); write only while idle.
// Sequence: a character, enter or tab request is accepted, then its press
// and release reports go out. A number request is accepted, converted
// bit-serially from binary to decimal, shifted past skipped leading digit
// positions, and then each typed digit is aligned, pressed and released.
// Requests that produce nothing leave the block ready next cycle.
// The single output register holds a report while out_stall is high; the
// block accepts a new request while its last report still waits.
// Reset clears the output register's valid and restores the configuration
// registers to 2, 40 and 43.
module keystroke_report_encoder_unit
    import kre_pkg::*;
#(
    parameter int MAX_DIGITS = 10
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_wdata,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [2:0]          action,
    input  logic [7:0]          char_code,
    input  logic [VALUE_W-1:0]  value,
    input  logic [7:0]          digit_count,
    input  logic                link_configured,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          modifier,
    output logic [7:0]          keycode,
    output logic                is_press,
    output logic                last
);

    localparam int MAXD = (MAX_DIGITS > NDIG) ? MAX_DIGITS : NDIG;
    localparam int PW   = $clog2(MAXD + 1);

    state_t state_reg, state_next;

    logic [7:0] shift_code_reg, enter_code_reg, tab_code_reg;

    logic          out_valid_reg, out_valid_next;
    logic [7:0]    modifier_reg, modifier_next;
    logic [7:0]    keycode_reg, keycode_next;
    logic          is_press_reg, is_press_next;
    logic          last_reg, last_next;

    logic [7:0]    pmod_reg, pmod_next;
    logic [7:0]    pkey_reg, pkey_next;
    logic          last_pair_reg, last_pair_next;
    logic          digit_reg, digit_next;
    logic          pad_reg, pad_next;
    logic          natural_reg, natural_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [PW-1:0] dpos_reg, dpos_next;

    dctrl_t    dctrl;
    dstat_t    dstat;
    char_map_t cmap;

    logic in_acc;
    logic out_free;
    logic fix_ok;
    logic skip;
    logic pad_now;

    kre_digit_unit u_digit
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (dctrl),
        .value (value),
        .stat  (dstat)
    );

    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign fix_ok   = (digit_count != 8'd0) && (digit_count <= 8'(MAX_DIGITS));
    assign cmap     = char_map(char_code);
    assign pad_now  = (pos_reg > dpos_reg);
    assign skip     = (pos_reg < dpos_reg)
                   || (natural_reg && (pos_reg == dpos_reg) && (dstat.top == 4'd0)
                       && (pos_reg > PW'(1)));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && link_configured)
                begin
                    case (action)
                        ACT_CHAR, ACT_ENTER, ACT_TAB: state_next = ST_PRESS;
                        ACT_NUM_NAT:                  state_next = ST_CONV;
                        ACT_NUM_FIX:
                        begin
                            if (fix_ok)
                                state_next = ST_CONV;
                        end
                        default:                      state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CONV:
            begin
                if (!dstat.busy)
                    state_next = ST_ALIGN;
            end
            ST_ALIGN:
            begin
                if (!skip)
                    state_next = ST_PRESS;
            end
            ST_PRESS:
            begin
                if (out_free)
                    state_next = ST_RELEASE;
            end
            ST_RELEASE:
            begin
                if (out_free)
                    state_next = (digit_reg && !last_pair_reg) ? ST_ALIGN : ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        dctrl          = '0;
        out_valid_next = out_valid_reg && out_stall;
        modifier_next  = modifier_reg;
        keycode_next   = keycode_reg;
        is_press_next  = is_press_reg;
        last_next      = last_reg;
        pmod_next      = pmod_reg;
        pkey_next      = pkey_reg;
        last_pair_next = last_pair_reg;
        digit_next     = digit_reg;
        pad_next       = pad_reg;
        natural_next   = natural_reg;
        pos_next       = pos_reg;
        dpos_next      = dpos_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    dctrl.load     = 1'b1;
                    last_pair_next = 1'b1;
                    digit_next     = 1'b0;
                    pad_next       = 1'b0;
                    natural_next   = (action == ACT_NUM_NAT);
                    dpos_next      = PW'(NDIG);
                    pmod_next      = 8'd0;
                    pkey_next      = 8'd0;
                    if (action == ACT_NUM_NAT)
                        pos_next = PW'(NDIG);
                    else
                        pos_next = PW'(digit_count);
                    case (action)
                        ACT_CHAR:
                        begin
                            pmod_next = cmap.upper ? shift_code_reg : 8'd0;
                            pkey_next = cmap.key;
                        end
                        ACT_ENTER:   pkey_next  = enter_code_reg;
                        ACT_TAB:     pkey_next  = tab_code_reg;
                        ACT_NUM_NAT: digit_next = 1'b1;
                        ACT_NUM_FIX: digit_next = 1'b1;
                        default:     digit_next = 1'b0;
                    endcase
                end
            end
            ST_ALIGN:
            begin
                if (skip)
                begin
                    dctrl.shift = 1'b1;
                    dpos_next   = dpos_reg - PW'(1);
                    if (pos_reg == dpos_reg)
                        pos_next = pos_reg - PW'(1);
                end
                else
                begin
                    natural_next   = 1'b0;
                    pad_next       = pad_now;
                    pmod_next      = 8'd0;
                    pkey_next      = digit_key(pad_now ? 4'd0 : dstat.top);
                    last_pair_next = (pos_reg == PW'(1));
                end
            end
            ST_PRESS:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    modifier_next  = pmod_reg;
                    keycode_next   = pkey_reg;
                    is_press_next  = 1'b1;
                    last_next      = 1'b0;
                end
            end
            ST_RELEASE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    modifier_next  = 8'd0;
                    keycode_next   = 8'd0;
                    is_press_next  = 1'b0;
                    last_next      = last_pair_reg;
                    if (digit_reg && !last_pair_reg)
                    begin
                        pos_next = pos_reg - PW'(1);
                        if (!pad_reg)
                        begin
                            dctrl.shift = 1'b1;
                            dpos_next   = dpos_reg - PW'(1);
                        end
                    end
                end
            end
            default: dctrl = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            shift_code_reg <= 8'd2;
            enter_code_reg <= 8'd40;
            tab_code_reg   <= 8'd43;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SHIFT: shift_code_reg <= cfg_wdata;
                    CFG_ENTER: enter_code_reg <= cfg_wdata;
                    CFG_TAB:   tab_code_reg   <= cfg_wdata;
                    default:   tab_code_reg   <= tab_code_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        modifier_reg  <= modifier_next;
        keycode_reg   <= keycode_next;
        is_press_reg  <= is_press_next;
        last_reg      <= last_next;
        pmod_reg      <= pmod_next;
        pkey_reg      <= pkey_next;
        last_pair_reg <= last_pair_next;
        digit_reg     <= digit_next;
        pad_reg       <= pad_next;
        natural_reg   <= natural_next;
        pos_reg       <= pos_next;
        dpos_reg      <= dpos_next;
    end

    assign out_valid = out_valid_reg;
    assign modifier  = modifier_reg;
    assign keycode   = keycode_reg;
    assign is_press  = is_press_reg;
    assign last      = last_reg;

    a_press_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_press) |-> !last)
        else $error("press beat marked last");

    a_release_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !is_press) |-> (modifier == 8'd0 && keycode == 8'd0))
        else $error("release beat carries nonzero data");

    a_release_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && is_press) |=> (out_valid && !is_press))
        else $error("release beat does not follow press");

    a_align_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ALIGN) |-> (pos_reg != '0 && dpos_reg <= PW'(NDIG)))
        else $error("digit position out of range");

endmodule

[test/tb_keystroke_report_encoder_unit.sv]
`timescale 1ns / 100ps

module tb_keystroke_report_encoder_unit;
    import kre_pkg::*;

    localparam int MAX_DIGITS      = 10;
    localparam int SETTLE_CYCLES   = 80;
    localparam int WATCHDOG_CYCLES = 2000;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int MAX_REPORTS     = 200;

    localparam logic [2:0] ACT_SPARE_LO = 3'd5;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_1 = 8'h31;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_AT      = 8'h40;
    localparam logic [7:0] CH_BRACE   = 8'h7B;
    localparam logic [7:0] CH_UPPER_Q = 8'h51;

    localparam logic [7:0] UPPER_OFFSET = 8'd61;
    localparam logic [7:0] LOWER_OFFSET = 8'd93;
    localparam logic [7:0] DIGIT_OFFSET = 8'd19;
    localparam logic [7:0] KEY_DIGIT_0  = 8'd39;

    typedef struct packed {
        logic [7:0] modifier;
        logic [7:0] keycode;
        logic       is_press;
        logic       last;
    } report_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_wdata;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  action;
    logic [7:0]  char_code;
    logic [31:0] value;
    logic [7:0]  digit_count;
    logic        link_configured;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  modifier;
    logic [7:0]  keycode;
    logic        is_press;
    logic        last;

    report_t pending_reports[$];
    report_t head_report;

    logic [7:0] shift_mod_reg;
    logic [7:0] enter_key_reg;
    logic [7:0] tab_key_reg;

    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int hold_cycles   = 0;
    int idle_count    = 0;
    int errors        = 0;
    int requests_sent = 0;
    int busy_requests = 0;
    int reports_seen  = 0;
    int cfg_writes    = 0;

    keystroke_report_encoder_unit #(
        .MAX_DIGITS(MAX_DIGITS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .action(action),
        .char_code(char_code),
        .value(value),
        .digit_count(digit_count),
        .link_configured(link_configured),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .modifier(modifier),
        .keycode(keycode),
        .is_press(is_press),
        .last(last)
    );

    always #10 clk = ~clk;

    function automatic void push_keystroke(input logic [7:0] mod, input logic [7:0] key);
        report_t press;
        report_t release_rpt;
        press       = '{modifier: mod, keycode: key, is_press: 1'b1, last: 1'b0};
        release_rpt = '{modifier: 8'd0, keycode: 8'd0, is_press: 1'b0, last: 1'b0};
        pending_reports.push_back(press);
        pending_reports.push_back(release_rpt);
    endfunction

    function automatic void type_char(input logic [7:0] c);
        logic [7:0] mod;
        logic [7:0] key;
        mod = 8'd0;
        key = 8'd0;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
        begin
            mod = shift_mod_reg;
            key = c - UPPER_OFFSET;
        end
        else if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
            key = c - LOWER_OFFSET;
        else if (c == CH_DIGIT_0)
            key = KEY_DIGIT_0;
        else if (c >= CH_DIGIT_1 && c <= CH_DIGIT_9)
            key = c - DIGIT_OFFSET;
        push_keystroke(mod, key);
    endfunction

    // Type the low cnt decimal digits of v, most significant first.
    function automatic void type_digits(input logic [31:0] v, input int cnt);
        logic [3:0]  digits [0:19];
        logic [31:0] rest;
        rest = v;
        for (int i = cnt - 1; i >= 0; i--)
        begin
            digits[i] = 4'(rest % 32'd10);
            rest      = rest / 32'd10;
        end
        for (int i = 0; i < cnt; i++)
            type_char(CH_DIGIT_0 + {4'd0, digits[i]});
    endfunction

    function automatic int expect_reports(input logic [2:0] act, input logic [7:0] c,
                                          input logic [31:0] v, input logic [7:0] n,
                                          input logic link);
        int          start_size;
        int          len;
        logic [31:0] rest;
        report_t     tail;
        start_size = pending_reports.size();
        if (link)
        begin
            case (act)
                ACT_CHAR:
                    type_char(c);
                ACT_NUM_NAT:
                begin
                    len  = 1;
                    rest = v / 32'd10;
                    while (rest != 0)
                    begin
                        len++;
                        rest = rest / 32'd10;
                    end
                    type_digits(v, len);
                end
                ACT_NUM_FIX:
                    if (n <= MAX_DIGITS)
                        type_digits(v, int'(n));
                ACT_ENTER:
                    push_keystroke(8'd0, enter_key_reg);
                ACT_TAB:
                    push_keystroke(8'd0, tab_key_reg);
                default:
                    ;
            endcase
        end
        if (pending_reports.size() > start_size)
        begin
            tail      = pending_reports.pop_back();
            tail.last = 1'b1;
            pending_reports.push_back(tail);
        end
        return pending_reports.size() - start_size;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            reports_seen++;
            if (pending_reports.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: report with none expected, expected nothing, got %0d/%0d/%0b/%0b",
                             $time, modifier, keycode, is_press, last);
            end
            else
            begin
                head_report = pending_reports.pop_front();
                check_field("modifier", head_report.modifier, modifier);
                check_field("keycode", head_report.keycode, keycode);
                check_field("is_press", {7'd0, head_report.is_press}, {7'd0, is_press});
                check_field("last", {7'd0, head_report.last}, {7'd0, last});
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall = 1'b1;
            hold_cycles--;
        end
        else
            out_stall = ($urandom_range(99) < sink_idle_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= WATCHDOG_CYCLES)
        begin
            $display("watchdog: no beat for %0d cycles at %0t", WATCHDOG_CYCLES, $time);
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_request(input logic [2:0] act, input logic [7:0] c,
                                input logic [31:0] v, input logic [7:0] n,
                                input logic link, output int produced);
        while ($urandom_range(99) < src_idle_pct)
            @(negedge clk);
        in_valid        = 1'b1;
        action          = act;
        char_code       = c;
        value           = v;
        digit_count     = n;
        link_configured = link;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        produced = expect_reports(act, c, v, n, link);
        requests_sent++;
        if (produced > 0)
            busy_requests++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic send(input logic [2:0] act, input logic [7:0] c, input logic [31:0] v,
                        input logic [7:0] n, input logic link);
        int produced;
        send_request(act, c, v, n, link, produced);
    endtask

    // Hold until every report is out, then let a silent request finish.
    task automatic wait_idle();
        while (pending_reports.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [7:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_SHIFT: shift_mod_reg = data;
            CFG_ENTER: enter_key_reg = data;
            CFG_TAB:   tab_key_reg   = data;
            default:   ;
        endcase
        cfg_writes++;
    endtask

    task automatic load_registers(input logic [7:0] shift_code, input logic [7:0] enter_code,
                                  input logic [7:0] tab_code);
        wait_idle();
        write_register(CFG_SHIFT, shift_code);
        write_register(CFG_ENTER, enter_code);
        write_register(CFG_TAB, tab_code);
    endtask

    task automatic test_reset_defaults();
        send(ACT_CHAR, CH_UPPER_A, 32'd0, 8'd0, 1'b1);
        send(ACT_ENTER, 8'd0, 32'd0, 8'd0, 1'b1);
        send(ACT_TAB, 8'd0, 32'd0, 8'd0, 1'b1);
    endtask

    task automatic test_characters();
        send(ACT_CHAR, CH_UPPER_Z, 32'd0, 8'd0, 1'b1);
        send(ACT_CHAR, CH_LOWER_A, 32'd0, 8'd0, 1'b1);
        send(ACT_CHAR, CH_LOWER_Z, 32'd0, 8'd0, 1'b1);
        send(ACT_CHAR, CH_DIGIT_0, 32'd0, 8'd0, 1'b1);
        send(ACT_CHAR, CH_DIGIT_1, 32'd0, 8'd0, 1'b1);
        send(ACT_CHAR, CH_DIGIT_9, 32'd0, 8'd0, 1'b1);
        send(ACT_CHAR, CH_AT, 32'd0, 8'd0, 1'b1);
        send(ACT_CHAR, CH_BRACE, 32'd0, 8'd0, 1'b1);
        send(ACT_CHAR, 8'h00, 32'hFFFF_FFFF, 8'hFF, 1'b1);
        send(ACT_CHAR, 8'hFF, 32'd0, 8'd0, 1'b1);
    endtask

    task automatic test_numbers();
        send(ACT_NUM_NAT, 8'd0, 32'd0, 8'd0, 1'b1);
        send(ACT_NUM_NAT, 8'd0, 32'hFFFF_FFFF, 8'd0, 1'b1);
        send(ACT_NUM_FIX, 8'd0, 32'd1234, 8'd0, 1'b1);
        send(ACT_NUM_FIX, 8'd0, 32'd42, 8'd10, 1'b1);
        send(ACT_NUM_FIX, 8'd0, 32'hFFFF_FFFF, 8'd3, 1'b1);
        send(ACT_NUM_FIX, 8'd0, 32'd987, 8'd11, 1'b1);
        send(ACT_NUM_FIX, 8'hFF, 32'd5, 8'd255, 1'b1);
    endtask

    task automatic test_silent_requests();
        send(ACT_SPARE_LO, CH_UPPER_A, 32'd7, 8'd3, 1'b1);
        send(ACT_SPARE_HI, CH_UPPER_A, 32'd7, 8'd3, 1'b1);
        send(ACT_CHAR, CH_UPPER_A, 32'd0, 8'd0, 1'b0);
        send(ACT_NUM_NAT, 8'd0, 32'd12345, 8'd0, 1'b0);
    endtask

    task automatic test_register_sweep();
        logic [7:0] settings [0:3][0:2];
        settings[0] = '{8'd0, 8'd0, 8'd0};
        settings[1] = '{8'd255, 8'd255, 8'd255};
        settings[2] = '{8'($urandom), 8'($urandom), 8'($urandom)};
        settings[3] = '{8'd255, 8'd0, 8'($urandom)};
        for (int s = 0; s < 4; s++)
        begin
            load_registers(settings[s][0], settings[s][1], settings[s][2]);
            send(ACT_CHAR, CH_UPPER_Q, 32'd0, 8'd0, 1'b1);
            send(ACT_ENTER, 8'd0, 32'd0, 8'd0, 1'b1);
            send(ACT_TAB, 8'd0, 32'd0, 8'd0, 1'b1);
        end
    endtask

    // Stall the report side while requests keep coming, then drain.
    task automatic test_output_holdoff();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        hold_cycles   = HOLD_OFF_CYCLES;
        for (int i = 0; i < 6; i++)
        begin
            send(ACT_NUM_FIX, 8'd0, $urandom, 8'd10, 1'b1);
            send(ACT_CHAR, CH_UPPER_A + 8'($urandom_range(25)), 32'd0, 8'd0, 1'b1);
        end
        wait_idle();
    endtask

    task automatic test_random_traffic(input int src_pct, input int sink_pct, input int want);
        int          got;
        int          produced;
        logic [2:0]  act;
        logic [7:0]  c;
        logic [31:0] v;
        logic [31:0] p;
        logic [7:0]  n;
        logic        link;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        got = 0;
        while (got < want)
        begin
            if ($urandom_range(99) < 85)
                act = 3'($urandom_range(4));
            else
                act = 3'($urandom_range(7, 5));
            case ($urandom_range(3))
                0:       c = CH_UPPER_A + 8'($urandom_range(25));
                1:       c = CH_LOWER_A + 8'($urandom_range(25));
                2:       c = CH_DIGIT_0 + 8'($urandom_range(9));
                default: c = 8'($urandom);
            endcase
            case ($urandom_range(3))
                0:       v = $urandom_range(9);
                1:       v = $urandom_range(99999);
                2:       v = $urandom;
                default:
                begin
                    p = 32'd1;
                    repeat ($urandom_range(9, 1)) p = p * 32'd10;
                    v = $urandom_range(1) ? p : p - 32'd1;
                end
            endcase
            case ($urandom_range(19))
                0:       n = 8'd0;
                1, 2:    n = 8'($urandom_range(255, 11));
                default: n = 8'($urandom_range(MAX_DIGITS, 1));
            endcase
            link = ($urandom_range(99) < 90);
            send_request(act, c, v, n, link, produced);
            if (produced > 0)
                got++;
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_SHIFT;
        cfg_wdata       = 8'd0;
        in_valid        = 1'b0;
        action          = ACT_CHAR;
        char_code       = 8'd0;
        value           = 32'd0;
        digit_count     = 8'd0;
        link_configured = 1'b0;
        shift_mod_reg   = 8'd2;
        enter_key_reg   = 8'd40;
        tab_key_reg     = 8'd43;
        src_idle_pct    = 16;
        sink_idle_pct   = 77;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_characters();
        test_numbers();
        test_silent_requests();
        test_register_sweep();
        test_output_holdoff();

        load_registers(8'($urandom), 8'($urandom), 8'($urandom));
        test_random_traffic(16, 77, 35);
        load_registers(8'($urandom), 8'($urandom), 8'($urandom));
        test_random_traffic(77, 16, 35);
        load_registers(8'd2, 8'd40, 8'd43);
        test_random_traffic(0, 0, 35);
        wait_idle();

        $display("Covered %0d requests (%0d typing something) and %0d reports,",
                 requests_sent, busy_requests, reports_seen);
        $display("with %0d register writes, three pacing mixes and a long report hold-off.",
                 cfg_writes);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
